### rtl/core/plenv_pkg.sv
// Shared types and constants for the positional list engine.
`default_nettype none

package plenv_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int CAPACITY_MAX = 1024;
    localparam int IDX_MAX_W    = $clog2(CAPACITY_MAX);
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int REQ_W        = 3;
    localparam int LEN_W        = 7;
    localparam int GROUP_SIZE   = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ   = 3'd0,
        REQ_HEAD   = 3'd1,
        REQ_TAIL   = 3'd2,
        REQ_AT     = 3'd3,
        REQ_DELETE = 3'd4
    } req_kind_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_READ
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [IDX_MAX_W-1:0]   pos;
    } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/core/positional_list_engine.sv
// Top level: ordered list held in a shifting chain of cells, with read gather.
// A result strobes on done after its request has passed the s1_valid_reg and done_reg registers.
// Throughput: one request per cycle; busy stays low, and all cells shift together.
// The read path is a registered OR gather over groups of eight cells, then one final OR.
// Reset clears the count and the pipeline valid and done flags; cell contents are not reset.
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = plenv_pkg::CAPACITY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [plenv_pkg::REQ_W-1:0]       req_type,
    input  wire logic signed [plenv_pkg::POS_W-1:0] position,
    input  wire logic signed [plenv_pkg::DATA_W-1:0] data_in,
    output logic                                   done,
    output logic signed [plenv_pkg::DATA_W-1:0]    read_data,
    output logic                                   read_valid,
    output logic                                   done_ok,
    output logic      [plenv_pkg::LEN_W-1:0]       list_length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > plenv_pkg::POS_W - 1) ? CW : plenv_pkg::POS_W - 1;
    localparam int NG = (CAPACITY + plenv_pkg::GROUP_SIZE - 1) / plenv_pkg::GROUP_SIZE;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic [plenv_pkg::DATA_W-1:0] cell_value [CAPACITY];
    logic [plenv_pkg::DATA_W-1:0] cell_term  [CAPACITY];

    plenv_pkg::cell_cmd_t cmd;
    logic                 accept;
    logic                 ok;
    logic                 is_read;
    logic [PW-1:0]        pos_ext;
    logic [PW-1:0]        cnt_ext;
    logic [PW-1:0]        target;
    logic                 neg;
    logic                 full;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                         s1_valid_reg;
    logic                         s1_read_reg;
    logic                         s1_ok_reg;
    logic [plenv_pkg::LEN_W-1:0]  s1_len_reg;
    logic [plenv_pkg::DATA_W-1:0] group_reg  [NG];
    logic [plenv_pkg::DATA_W-1:0] group_next [NG];
    logic [plenv_pkg::DATA_W-1:0] gather;

    logic                         done_reg;
    logic [plenv_pkg::DATA_W-1:0] read_data_reg;
    logic                         read_valid_reg;
    logic                         done_ok_reg;
    logic [plenv_pkg::LEN_W-1:0]  list_length_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign neg    = position[plenv_pkg::POS_W-1];
    assign pos_ext = PW'(position[plenv_pkg::POS_W-2:0]);
    assign cnt_ext = PW'(count_reg);
    assign full    = (count_reg == FULL_COUNT);

    always_comb
    begin
        cmd.op     = plenv_pkg::CELL_HOLD;
        target     = '0;
        ok         = 1'b0;
        is_read    = 1'b0;
        count_next = count_reg;
        if (accept)
        begin
            unique case (req_type)
                plenv_pkg::REQ_READ:
                begin
                    if (!neg && pos_ext < cnt_ext)
                    begin
                        cmd.op  = plenv_pkg::CELL_READ;
                        target  = pos_ext;
                        ok      = 1'b1;
                        is_read = 1'b1;
                    end
                end
                plenv_pkg::REQ_HEAD:
                begin
                    if (!full)
                    begin
                        cmd.op     = plenv_pkg::CELL_INSERT;
                        ok         = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                plenv_pkg::REQ_TAIL:
                begin
                    if (!full)
                    begin
                        cmd.op     = plenv_pkg::CELL_INSERT;
                        target     = cnt_ext;
                        ok         = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                plenv_pkg::REQ_AT:
                begin
                    if (!full && (neg || pos_ext <= cnt_ext))
                    begin
                        cmd.op     = plenv_pkg::CELL_INSERT;
                        target     = neg ? '0 : pos_ext;
                        ok         = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                plenv_pkg::REQ_DELETE:
                begin
                    if (!neg && pos_ext < cnt_ext)
                    begin
                        cmd.op     = plenv_pkg::CELL_DELETE;
                        target     = pos_ext;
                        ok         = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    cmd.op = plenv_pkg::CELL_HOLD;
                end
            endcase
        end
        cmd.pos = plenv_pkg::IDX_MAX_W'(target);
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [plenv_pkg::DATA_W-1:0] left_v;
        logic [plenv_pkg::DATA_W-1:0] right_v;
        if (i == 0)
        begin : g_first
            assign left_v = data_in;
        end
        else
        begin : g_mid_l
            assign left_v = cell_value[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = cell_value[i];
        end
        else
        begin : g_mid_r
            assign right_v = cell_value[i+1];
        end
        plenv_cell #(
            .IDX(i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .left_value  (left_v),
            .right_value (right_v),
            .data_in     (data_in),
            .value       (cell_value[i]),
            .read_term   (cell_term[i])
        );
    end

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < plenv_pkg::GROUP_SIZE; j++)
            begin
                if (g * plenv_pkg::GROUP_SIZE + j < CAPACITY)
                    group_next[g] = group_next[g] | cell_term[g * plenv_pkg::GROUP_SIZE + j];
            end
        end
    end

    always_comb
    begin
        gather = '0;
        for (int g = 0; g < NG; g++)
        begin
            gather = gather | group_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_read_reg     <= is_read;
        s1_ok_reg       <= ok;
        s1_len_reg      <= plenv_pkg::LEN_W'(count_next);
        group_reg       <= group_next;
        read_data_reg   <= s1_read_reg ? gather : '1;
        read_valid_reg  <= s1_read_reg;
        done_ok_reg     <= s1_ok_reg;
        list_length_reg <= s1_len_reg;
    end

    assign done        = done_reg;
    assign read_data   = read_data_reg;
    assign read_valid  = read_valid_reg;
    assign done_ok     = done_ok_reg;
    assign list_length = list_length_reg;

    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("request did not produce a result two cycles later");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> done)
        else $error("result strobe missing after gather stage");

    a_valid_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && read_valid |-> done_ok)
        else $error("valid read reported as failed");

    a_failed_read_ones: assert property (@(posedge clk) disable iff (!rst_n)
        done && !read_valid |-> read_data == '1)
        else $error("read data not all ones without a valid read");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("element count above capacity");

endmodule

`default_nettype wire

### rtl/core/plenv_cell.sv
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
`default_nettype none

module plenv_cell #(
    parameter int IDX = 0
) (
    input  wire logic                          clk,
    input  wire plenv_pkg::cell_cmd_t          cmd,
    input  wire logic [plenv_pkg::DATA_W-1:0]  left_value,
    input  wire logic [plenv_pkg::DATA_W-1:0]  right_value,
    input  wire logic [plenv_pkg::DATA_W-1:0]  data_in,
    output logic      [plenv_pkg::DATA_W-1:0]  value,
    output logic      [plenv_pkg::DATA_W-1:0]  read_term
);

    localparam logic [plenv_pkg::IDX_MAX_W-1:0] MY_IDX = plenv_pkg::IDX_MAX_W'(IDX);

    logic [plenv_pkg::DATA_W-1:0] value_reg;
    logic [plenv_pkg::DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.op)
            plenv_pkg::CELL_INSERT:
            begin
                if (cmd.pos < MY_IDX)
                    value_next = left_value;
                else if (cmd.pos == MY_IDX)
                    value_next = data_in;
            end
            plenv_pkg::CELL_DELETE:
            begin
                if (cmd.pos <= MY_IDX)
                    value_next = right_value;
            end
            plenv_pkg::CELL_READ,
            plenv_pkg::CELL_HOLD:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign read_term = (cmd.op == plenv_pkg::CELL_READ && cmd.pos == MY_IDX)
                       ? value_reg : '0;

endmodule

`default_nettype wire

### sim/tb.sv
// Testbench for positional_list_engine: directed and random requests checked against a list predictor.
module tb;

    import plenv_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;

    // request kinds outside the defined set
    localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] rdata;
        logic                     rvalid;
        logic                     ok;
        logic [LEN_W-1:0]         len;
    } list_result_t;

    typedef struct packed {
        logic [REQ_W-1:0]         kind;
        logic signed [POS_W-1:0]  pos;
        logic [DATA_W-1:0]        val;
        logic                     typed;
        list_result_t             want;
    } stim_row_t;

    typedef enum {PH_GROW, PH_SHRINK, PH_MIX} phase_mode_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [REQ_W-1:0]           req_type = '0;
    logic signed [POS_W-1:0]    position = '0;
    logic signed [DATA_W-1:0]   data_in = '0;
    logic                       busy;
    logic                       done;
    logic signed [DATA_W-1:0]   read_data;
    logic                       read_valid;
    logic                       done_ok;
    logic [LEN_W-1:0]           list_length;

    logic signed [DATA_W-1:0]   list_model[$];
    list_result_t               pending_results[$];
    stim_row_t                  directed_rows[$];
    int                         mismatch_count = 0;
    int                         sent_count = 0;

    positional_list_engine #(
        .CAPACITY    (LIST_CAP)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .position    (position),
        .data_in     (data_in),
        .done        (done),
        .read_data   (read_data),
        .read_valid  (read_valid),
        .done_ok     (done_ok),
        .list_length (list_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic list_result_t apply_request(input logic [REQ_W-1:0] kind,
                                                   input logic signed [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] val);
        list_result_t r;
        int           p;
        int           cnt;
        r.rdata  = -1;
        r.rvalid = 1'b0;
        r.ok     = 1'b0;
        p        = pos;
        cnt      = list_model.size();
        case (kind)
            REQ_READ:
            begin
                if (p >= 0 && p < cnt)
                begin
                    r.rdata  = list_model[p];
                    r.rvalid = 1'b1;
                    r.ok     = 1'b1;
                end
            end
            REQ_HEAD, REQ_TAIL, REQ_AT:
            begin
                if (kind == REQ_HEAD)
                    p = 0;
                else if (kind == REQ_TAIL)
                    p = cnt;
                else if (p < 0)
                    p = 0;
                if (cnt < LIST_CAP && p <= cnt)
                begin
                    list_model.insert(p, val);
                    r.ok = 1'b1;
                end
            end
            REQ_DELETE:
            begin
                if (p >= 0 && p < cnt)
                begin
                    list_model.delete(p);
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.len = LEN_W'(list_model.size());
        return r;
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [POS_W-1:0] pick_pos(input logic [REQ_W-1:0] kind);
        int r;
        int cnt;
        r   = $urandom_range(0, 99);
        cnt = list_model.size();
        if (r < 70)
        begin
            if (kind == REQ_HEAD || kind == REQ_TAIL || kind == REQ_AT)
                return POS_W'($urandom_range(0, cnt));
            else
                return (cnt == 0) ? '0 : POS_W'($urandom_range(0, cnt - 1));
        end
        else if (r < 85)
            return POS_W'($urandom());
        case ($urandom_range(0, 4))
            0:       return -1;
            1:       return -128;
            2:       return 127;
            3:       return POS_W'(cnt);
            default: return POS_W'(cnt + 1);
        endcase
    endfunction

    task automatic add_row(input logic [REQ_W-1:0] kind, input logic signed [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] val, input logic typed,
                           input logic signed [DATA_W-1:0] rdata, input logic rvalid,
                           input logic ok, input logic [LEN_W-1:0] len);
        stim_row_t row;
        row.kind         = kind;
        row.pos          = pos;
        row.val          = val;
        row.typed        = typed;
        row.want.rdata   = rdata;
        row.want.rvalid  = rvalid;
        row.want.ok      = ok;
        row.want.len     = len;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input logic [REQ_W-1:0] kind, input logic signed [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val, input logic typed,
                                input list_result_t want, input int gap);
        list_result_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= kind;
        position <= pos;
        data_in  <= val;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = apply_request(kind, pos, val);
        pending_results.push_back(typed ? want : predicted);
        sent_count++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: data %h valid %b ok %b len %0d",
                             read_data, read_valid, done_ok, list_length);
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.rdata || read_valid !== want.rvalid ||
                    done_ok !== want.ok || list_length !== want.len)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp data %h valid %b ok %b len %0d, got data %h valid %b ok %b len %0d",
                                 want.rdata, want.rvalid, want.ok, want.len,
                                 read_data, read_valid, done_ok, list_length);
                end
            end
        end
    end

    initial
    begin
        phase_mode_t             mode;
        logic [REQ_W-1:0]        kind;
        logic signed [POS_W-1:0] pos;
        list_result_t            none;
        bit                      steady;
        int                      phase;
        int                      n;
        int                      extra;
        int                      r;

        none = '0;

        // empty list, extremes, every kind and the out-of-range and reserved-kind failure paths
        add_row(REQ_READ,   0,    32'h0,        1'b1, -1, 1'b0, 1'b0, 0);
        add_row(REQ_DELETE, 0,    32'h0,        1'b1, -1, 1'b0, 1'b0, 0);
        add_row(REQ_AT,     1,    32'h1,        1'b1, -1, 1'b0, 1'b0, 0);
        add_row(REQ_HEAD,   0,    32'h7FFFFFFF, 1'b1, -1, 1'b0, 1'b1, 1);
        add_row(REQ_TAIL,   0,    32'h80000000, 1'b1, -1, 1'b0, 1'b1, 2);
        add_row(REQ_AT,     -128, 32'h0,        1'b1, -1, 1'b0, 1'b1, 3);
        add_row(REQ_AT,     3,    32'hFFFFFFFF, 1'b0, 0,  1'b0, 1'b0, 0);
        add_row(REQ_AT,     127,  32'h12345678, 1'b1, -1, 1'b0, 1'b0, 4);
        add_row(REQ_READ,   0,    32'h0,        1'b0, 0,  1'b0, 1'b0, 0);
        add_row(REQ_READ,   3,    32'h0,        1'b0, 0,  1'b0, 1'b0, 0);
        add_row(REQ_READ,   -1,   32'h0,        1'b1, -1, 1'b0, 1'b0, 4);
        add_row(REQ_READ,   4,    32'h0,        1'b1, -1, 1'b0, 1'b0, 4);
        add_row(REQ_READ,   127,  32'h0,        1'b1, -1, 1'b0, 1'b0, 4);
        add_row(REQ_DELETE, -128, 32'h0,        1'b1, -1, 1'b0, 1'b0, 4);
        add_row(REQ_DELETE, 4,    32'h0,        1'b1, -1, 1'b0, 1'b0, 4);
        add_row(REQ_DELETE, 3,    32'h0,        1'b0, 0,  1'b0, 1'b0, 0);
        add_row(REQ_RSVD5,  0,    32'hFFFFFFFF, 1'b1, -1, 1'b0, 1'b0, 3);
        add_row(REQ_RSVD6,  -1,   32'h0,        1'b1, -1, 1'b0, 1'b0, 3);
        add_row(REQ_RSVD7,  127,  32'h80000000, 1'b1, -1, 1'b0, 1'b0, 3);
        add_row(REQ_AT,     2,    32'h55555555, 1'b0, 0,  1'b0, 1'b0, 0);
        add_row(REQ_AT,     -1,   32'hAAAAAAAA, 1'b0, 0,  1'b0, 1'b0, 0);
        add_row(REQ_READ,   1,    32'h0,        1'b0, 0,  1'b0, 1'b0, 0);
        add_row(REQ_DELETE, 0,    32'h0,        1'b0, 0,  1'b0, 1'b0, 0);
        add_row(REQ_READ,   0,    32'h0,        1'b0, 0,  1'b0, 1'b0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].val,
                         directed_rows[i].typed, directed_rows[i].want, pick_gap(1'b0));
        wait_idle();

        // grow to full, drain to empty, then a mixed stretch; repeat
        for (phase = 0; sent_count < 600; phase++)
        begin
            mode   = phase_mode_t'(phase % 3);
            steady = (phase % 4 == 3);
            n      = 0;
            extra  = 0;
            while (n < 200)
            begin
                r = $urandom_range(0, 99);
                case (mode)
                    PH_GROW:
                        kind = (r < 30) ? REQ_HEAD : (r < 60) ? REQ_TAIL :
                               (r < 85) ? REQ_AT : (r < 95) ? REQ_READ : REQ_DELETE;
                    PH_SHRINK:
                        kind = (r < 45) ? REQ_DELETE : (r < 70) ? REQ_READ :
                               (r < 80) ? REQ_HEAD : (r < 85) ? REQ_TAIL :
                               (r < 95) ? REQ_AT : REQ_W'($urandom_range(REQ_RSVD5, REQ_RSVD7));
                    default:
                        kind = (r < 20) ? REQ_READ : (r < 35) ? REQ_HEAD :
                               (r < 50) ? REQ_TAIL : (r < 65) ? REQ_AT :
                               (r < 90) ? REQ_DELETE :
                               REQ_W'($urandom_range(REQ_RSVD5, REQ_RSVD7));
                endcase
                pos = pick_pos(kind);
                send_request(kind, pos, $urandom(), 1'b0, none, pick_gap(steady));
                n++;
                if (mode == PH_GROW && list_model.size() == LIST_CAP)
                    extra++;
                if (mode == PH_SHRINK && list_model.size() == 0)
                    extra++;
                if ((mode == PH_GROW && extra > 10) || (mode == PH_SHRINK && extra > 6) ||
                    (mode == PH_MIX && n >= 80))
                    break;
            end
            wait_idle();
        end

        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
